// File: rtl/core/bsm_pkg.sv
`timescale 1ns / 1ps
// Shared types and decode constants for the bank switch mapper core.
// No dependencies; imported by the core, decode and state modules.
package bsm_pkg;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_TICK  = 1'b1
  } action_t;

  localparam logic [15:0] ADDR_MASK = 16'hF0CF;

  // Upper nibble of the masked address
  localparam logic [3:0] HI_PRG_LOW  = 4'h8;
  localparam logic [3:0] HI_MODE     = 4'h9;
  localparam logic [3:0] HI_PRG_MID  = 4'hA;
  localparam logic [3:0] HI_CHR01    = 4'hB;
  localparam logic [3:0] HI_CHR23    = 4'hC;
  localparam logic [3:0] HI_CHR45    = 4'hD;
  localparam logic [3:0] HI_CHR67    = 4'hE;
  localparam logic [3:0] HI_IRQ      = 4'hF;

  // Low byte of the masked address, named by the address lines that are set
  localparam logic [7:0] LO_NONE = 8'h00;
  localparam logic [7:0] LO_A0   = 8'h01;
  localparam logic [7:0] LO_A1   = 8'h02;
  localparam logic [7:0] LO_A0A1 = 8'h03;
  localparam logic [7:0] LO_A2   = 8'h04;
  localparam logic [7:0] LO_A1A2 = 8'h06;
  localparam logic [7:0] LO_A6   = 8'h40;
  localparam logic [7:0] LO_A7   = 8'h80;
  localparam logic [7:0] LO_A6A7 = 8'hC0;

  localparam logic [1:0] PRG_SLOT_8000 = 2'd0;
  localparam logic [1:0] PRG_SLOT_A000 = 2'd1;
  localparam logic [1:0] PRG_SLOT_C000 = 2'd2;

  localparam logic [7:0] CNT_MAX  = 8'hFF;
  localparam int         CHR_REGS = 8;

  typedef struct packed {
    logic [CHR_REGS-1:0][7:0] chr;
    logic [7:0]               mode;
    logic [7:0]               irq_reload;
    logic [7:0]               irq_count;
    logic [1:0]               irq_ctrl;
  } bsm_state_t;

  typedef struct packed {
    logic       chr_we;
    logic [2:0] chr_idx;
    logic [7:0] chr_val;
    logic [7:0] mode;
    logic [7:0] irq_reload;
    logic [7:0] irq_count;
    logic [1:0] irq_ctrl;
  } bsm_upd_t;

  typedef struct packed {
    logic       prg_valid;
    logic [1:0] prg_slot;
    logic [7:0] prg_bank;
    logic       chr_valid;
    logic [2:0] chr_slot;
    logic [7:0] chr_bank;
    logic       mirror_valid;
    logic [1:0] mirror_mode;
    logic       irq_pulse;
  } bsm_res_t;

endpackage

// File: rtl/core/bank_switch_mapper_with_scanline_irq_core.sv
`timescale 1ns / 1ps
// Bank switch mapper core: input register, decode, result register.
// An item passes from the input register to the result register; while
// the output stalls, it waits in the input register.
// Throughput: one item per cycle unless the output stalls; state updates as
// an item leaves the input register, so the next item sees them directly.
// Reset clears both stage valids and loads the mapper state defaults.
// Depends on bsm_pkg, bsm_decode, bsm_state.
module bank_switch_mapper_with_scanline_irq_core import bsm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [15:0] addr,
  input  logic [7:0]  wdata,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        prg_valid,
  output logic [1:0]  prg_slot,
  output logic [7:0]  prg_bank,
  output logic        chr_valid,
  output logic [2:0]  chr_slot,
  output logic [7:0]  chr_bank,
  output logic        mirror_valid,
  output logic [1:0]  mirror_mode,
  output logic        irq_pulse
);

  logic        s1_valid;
  logic        s1_action;
  logic [15:0] s1_addr;
  logic [7:0]  s1_wdata;
  logic        s1_go;
  logic        in_take;
  bsm_state_t  st;
  bsm_upd_t    upd;
  bsm_res_t    res_next;
  bsm_res_t    res;

  assign s1_go    = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_go;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_action <= action;
      s1_addr   <= addr;
      s1_wdata  <= wdata;
    end
  end

  bsm_decode u_decode (
    .action (s1_action),
    .addr   (s1_addr),
    .wdata  (s1_wdata),
    .st     (st),
    .res    (res_next),
    .upd    (upd)
  );

  bsm_state u_state (
    .clk    (clk),
    .rst    (rst),
    .upd_en (s1_go),
    .upd    (upd),
    .st     (st)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // hold the result while the consumer stalls
  always_ff @(posedge clk) begin
    if (s1_go) begin
      res <= res_next;
    end
  end

  assign prg_valid    = res.prg_valid;
  assign prg_slot     = res.prg_slot;
  assign prg_bank     = res.prg_bank;
  assign chr_valid    = res.chr_valid;
  assign chr_slot     = res.chr_slot;
  assign chr_bank     = res.chr_bank;
  assign mirror_valid = res.mirror_valid;
  assign mirror_mode  = res.mirror_mode;
  assign irq_pulse    = res.irq_pulse;

endmodule

// File: rtl/core/bsm_decode.sv
`timescale 1ns / 1ps
// Write decode and scanline counter step: current state and one item in,
// result and next state out. Depends on bsm_pkg.
module bsm_decode import bsm_pkg::*; (
  input  logic       action,
  input  logic [15:0] addr,
  input  logic [7:0]  wdata,
  input  bsm_state_t  st,
  output bsm_res_t    res,
  output bsm_upd_t    upd
);

  logic [15:0] m;
  logic [3:0]  hi;
  logic [7:0]  lo;
  logic [3:0]  pair;
  logic        chr_hit;
  logic        odd;
  logic        high;
  logic [2:0]  idx;
  logic [7:0]  old;

  assign m    = addr & ADDR_MASK;
  assign hi   = m[15:12];
  assign lo   = m[7:0];
  assign pair = hi - HI_CHR01;
  assign idx  = {pair[1:0], odd};
  assign old  = st.chr[idx];

  always_comb begin
    chr_hit = 1'b1;
    odd     = 1'b0;
    high    = 1'b0;
    if (lo == LO_NONE) begin
      odd  = 1'b0;
      high = 1'b0;
    end else if (lo inside {LO_A1, LO_A6}) begin
      odd  = 1'b0;
      high = 1'b1;
    end else if (lo inside {LO_A0, LO_A2, LO_A7}) begin
      odd  = 1'b1;
      high = 1'b0;
    end else if (lo inside {LO_A0A1, LO_A1A2, LO_A6A7}) begin
      odd  = 1'b1;
      high = 1'b1;
    end else begin
      chr_hit = 1'b0;
    end
  end

  always_comb begin
    res            = '0;
    upd.chr_we     = 1'b0;
    upd.chr_idx    = idx;
    upd.chr_val    = high ? {wdata[3:0], old[3:0]} : {old[7:4], wdata[3:0]};
    upd.mode       = st.mode;
    upd.irq_reload = st.irq_reload;
    upd.irq_count  = st.irq_count;
    upd.irq_ctrl   = st.irq_ctrl;
    if (action == ACT_TICK) begin
      if (st.irq_ctrl[1]) begin
        if (st.irq_count == CNT_MAX) begin
          upd.irq_count = st.irq_reload;
          upd.irq_ctrl  = {2{st.irq_ctrl[0]}};
          res.irq_pulse = 1'b1;
        end else begin
          upd.irq_count = st.irq_count + 8'd1;
        end
      end
    end else begin
      case (hi)
        HI_PRG_LOW: begin
          if (lo == LO_NONE) begin
            res.prg_valid = 1'b1;
            res.prg_slot  = st.mode[1] ? PRG_SLOT_C000 : PRG_SLOT_8000;
            res.prg_bank  = wdata;
          end
        end
        HI_PRG_MID: begin
          if (lo == LO_NONE) begin
            res.prg_valid = 1'b1;
            res.prg_slot  = PRG_SLOT_A000;
            res.prg_bank  = wdata;
          end
        end
        HI_MODE: begin
          if (lo == LO_NONE) begin
            res.mirror_valid = 1'b1;
            res.mirror_mode  = wdata[1:0];
          end else if (lo inside {LO_A1, LO_A7}) begin
            upd.mode = wdata;
          end
        end
        HI_CHR01, HI_CHR23, HI_CHR45, HI_CHR67: begin
          if (chr_hit) begin
            upd.chr_we    = 1'b1;
            res.chr_valid = 1'b1;
            res.chr_slot  = idx;
            res.chr_bank  = upd.chr_val;
          end
        end
        HI_IRQ: begin
          if (lo == LO_NONE) begin
            upd.irq_reload = {st.irq_reload[7:4], wdata[3:0]};
          end else if (lo inside {LO_A1, LO_A6}) begin
            upd.irq_reload = {wdata[3:0], st.irq_reload[3:0]};
          end else if (lo inside {LO_A0A1, LO_A6A7}) begin
            // acknowledge: restore enable from the after-ack bit
            upd.irq_ctrl = {2{st.irq_ctrl[0]}};
          end else if (lo inside {LO_A2, LO_A7}) begin
            upd.irq_ctrl = wdata[1:0];
            if (wdata[1]) begin
              upd.irq_count = st.irq_reload;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: rtl/core/bsm_state.sv
`timescale 1ns / 1ps
// Mapper state registers: character banks, mode, IRQ latch, counter, control.
// Depends on bsm_pkg; loaded from the decode update on each transfer.
module bsm_state import bsm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       upd_en,
  input  bsm_upd_t   upd,
  output bsm_state_t st
);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHR_REGS; i++) begin
        st.chr[i] <= 8'(i);
      end
      st.mode       <= '0;
      st.irq_reload <= '0;
      st.irq_count  <= '0;
      st.irq_ctrl   <= '0;
    end else if (upd_en) begin
      if (upd.chr_we) begin
        st.chr[upd.chr_idx] <= upd.chr_val;
      end
      st.mode       <= upd.mode;
      st.irq_reload <= upd.irq_reload;
      st.irq_count  <= upd.irq_count;
      st.irq_ctrl   <= upd.irq_ctrl;
    end
  end

endmodule

// File: rtl/core/bsm_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the bank switch mapper core, attached by bind.
// Depends only on the top level's ports.
module bsm_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic       prg_valid,
  input logic [1:0] prg_slot,
  input logic [7:0] prg_bank,
  input logic       chr_valid,
  input logic [2:0] chr_slot,
  input logic [7:0] chr_bank,
  input logic       mirror_valid,
  input logic [1:0] mirror_mode,
  input logic       irq_pulse
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(prg_bank) && $stable(chr_bank)
      && $stable(irq_pulse))
    else $error("stalled result changed");

  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0({prg_valid, chr_valid, mirror_valid, irq_pulse}))
    else $error("result reports more than one kind of update");

  a_prg_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (prg_slot != 2'd3)
      && (prg_valid || (prg_slot == 2'd0 && prg_bank == 8'd0)))
    else $error("bad program slot fields");

  a_quiet_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (chr_valid || (chr_slot == 3'd0 && chr_bank == 8'd0))
      && (mirror_valid || mirror_mode == 2'd0))
    else $error("fields set without their valid bit");

endmodule

bind bank_switch_mapper_with_scanline_irq_core bsm_checker u_bsm_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .prg_valid    (prg_valid),
  .prg_slot     (prg_slot),
  .prg_bank     (prg_bank),
  .chr_valid    (chr_valid),
  .chr_slot     (chr_slot),
  .chr_bank     (chr_bank),
  .mirror_valid (mirror_valid),
  .mirror_mode  (mirror_mode),
  .irq_pulse    (irq_pulse)
);
